// File: sv/lfsc_pkg.sv
// Package for the line-following two-wheel speed controller.
// Holds register codes, stop causes, sensor patterns, reset values and shared types.
// No dependencies; lfsc_wheel, the top level and the checker import it.
package lfsc_pkg;

  localparam int POSITION_BITS_DEF  = 24;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 23;

  localparam int DELTA_BITS  = 10;
  localparam int SENSE_BITS  = 10;
  localparam int REF_BITS    = 10;
  localparam int GAIN_BITS   = 8;
  localparam int DRIVE_BITS  = 9;
  localparam int SPEED_LIMIT = 255;

  localparam logic [9:0]  LINE_THRESHOLD_RESET = 10'd900;
  localparam logic [7:0]  BASE_REFERENCE_RESET = 8'd30;
  localparam logic [7:0]  STEER_MINOR_RESET    = 8'd4;
  localparam logic [7:0]  STEER_MAJOR_RESET    = 8'd6;
  localparam logic [7:0]  SPEED_GAIN_RESET     = 8'd26;

  localparam logic ACTION_START = 1'b0;

  localparam logic [2:0] PAT_NONE        = 3'b000;
  localparam logic [2:0] PAT_CENTRE      = 3'b010;
  localparam logic [2:0] PAT_RIGHT_MINOR = 3'b011;
  localparam logic [2:0] PAT_RIGHT_MAJOR = 3'b001;
  localparam logic [2:0] PAT_LEFT_MINOR  = 3'b110;
  localparam logic [2:0] PAT_LEFT_MAJOR  = 3'b100;
  localparam logic [2:0] PAT_ALL         = 3'b111;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SEEK_MODE      = 3'd0,
    CFG_HORIZ_STOP     = 3'd1,
    CFG_TARGET_COUNTS  = 3'd2,
    CFG_LINE_THRESHOLD = 3'd3,
    CFG_BASE_REFERENCE = 3'd4,
    CFG_STEER_MINOR    = 3'd5,
    CFG_STEER_MAJOR    = 3'd6,
    CFG_SPEED_GAIN     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STOP_RUNNING    = 2'd0,
    STOP_DISTANCE   = 2'd1,
    STOP_HORIZONTAL = 2'd2,
    STOP_LINE       = 2'd3
  } stop_cause_t;

  typedef struct packed {
    logic clear;
    logic pos_en;
    logic speed_en;
  } wheel_ctrl_t;

endpackage

// File: sv/lfsc_if.sv
// Channel interfaces of the line-following speed controller.
// lfsc_in_if carries one sensor/encoder item, lfsc_out_if one drive result.
// Depends on nothing; widths follow the fixed field widths.
interface lfsc_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic signed [9:0] left_delta;
  logic signed [9:0] right_delta;
  logic        [9:0] sensor_left;
  logic        [9:0] sensor_centre;
  logic        [9:0] sensor_right;

  modport source (output valid, action, left_delta, right_delta, sensor_left,
                  sensor_centre, sensor_right, input ready);
  modport sink   (input valid, action, left_delta, right_delta, sensor_left,
                  sensor_centre, sensor_right, output ready);
endinterface

interface lfsc_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] left_drive;
  logic signed [8:0] right_drive;
  logic              brake;
  logic        [1:0] stop_cause;
  logic        [2:0] line_pattern;

  modport source (output valid, left_drive, right_drive, brake, stop_cause,
                  line_pattern, input ready);
  modport sink   (input valid, left_drive, right_drive, brake, stop_cause,
                  line_pattern, output ready);
endinterface

// File: sv/lfsc_wheel.sv
// One wheel: saturating position, Q-format speed loop and drive truncation.
// Depends on lfsc_pkg; instantiated twice by line_follow_speed_control.
module lfsc_wheel #(
  parameter int POSITION_BITS  = lfsc_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRAC_BITS = lfsc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lfsc_pkg::wheel_ctrl_t     ctrl,
  input  logic signed [9:0]         delta,
  input  logic signed [9:0]         reference,
  input  logic        [7:0]         gain,
  output logic [POSITION_BITS-1:0]  pos_mag,
  output logic signed [8:0]         drive
);
  import lfsc_pkg::*;

  localparam int SPEED_BITS = GAIN_FRAC_BITS + 9;
  localparam int DIFF_BITS  = REF_BITS + 1;
  localparam int PROD_BITS  = GAIN_BITS + 1 + DIFF_BITS;
  localparam int SUM_BITS   = ((SPEED_BITS > PROD_BITS) ? SPEED_BITS : PROD_BITS) + 1;

  localparam logic signed [POSITION_BITS:0] POS_HI =
    signed'({2'b00, {(POSITION_BITS-1){1'b1}}});
  localparam logic signed [POSITION_BITS:0] POS_LO =
    signed'({2'b11, {(POSITION_BITS-1){1'b0}}});
  localparam logic signed [SUM_BITS-1:0] SPEED_MAX =
    SUM_BITS'(SPEED_LIMIT * (2 ** GAIN_FRAC_BITS));
  localparam logic signed [SUM_BITS-1:0] SPEED_MIN = -SPEED_MAX;

  logic signed [POSITION_BITS-1:0] pos;
  logic signed [POSITION_BITS-1:0] pos_next;
  logic signed [POSITION_BITS:0]   pos_sum;
  logic signed [SPEED_BITS-1:0]    speed;
  logic signed [SPEED_BITS-1:0]    speed_next;
  logic signed [DIFF_BITS-1:0]     diff;
  logic signed [PROD_BITS-1:0]     prod;
  logic signed [SUM_BITS-1:0]      speed_sum;
  logic        [SPEED_BITS-1:0]    speed_abs;
  logic        [7:0]               drive_abs;

  always_comb begin
    pos_sum = (POSITION_BITS+1)'(pos) + (POSITION_BITS+1)'(delta);
    if (pos_sum > POS_HI) begin
      pos_next = POSITION_BITS'(POS_HI);
    end else if (pos_sum < POS_LO) begin
      pos_next = POSITION_BITS'(POS_LO);
    end else begin
      pos_next = POSITION_BITS'(pos_sum);
    end
    pos_mag = pos_next[POSITION_BITS-1] ? POSITION_BITS'(~pos_next + 1'b1)
                                        : POSITION_BITS'(pos_next);
  end

  always_comb begin
    diff      = DIFF_BITS'(reference) - DIFF_BITS'(delta);
    prod      = $signed({1'b0, gain}) * diff;
    speed_sum = SUM_BITS'(speed) + SUM_BITS'(prod);
    if (speed_sum > SPEED_MAX) begin
      speed_next = SPEED_BITS'(SPEED_MAX);
    end else if (speed_sum < SPEED_MIN) begin
      speed_next = SPEED_BITS'(SPEED_MIN);
    end else begin
      speed_next = SPEED_BITS'(speed_sum);
    end
    speed_abs = speed_next[SPEED_BITS-1] ? SPEED_BITS'(~speed_next + 1'b1)
                                         : SPEED_BITS'(speed_next);
    drive_abs = speed_abs[GAIN_FRAC_BITS +: 8];
    drive     = speed_next[SPEED_BITS-1] ? -$signed({1'b0, drive_abs})
                                         : $signed({1'b0, drive_abs});
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      pos   <= '0;
      speed <= '0;
    end else begin
      if (ctrl.pos_en) begin
        pos <= pos_next;
      end
      if (ctrl.speed_en) begin
        speed <= speed_next;
      end
    end
  end

endmodule

// File: sv/line_follow_speed_control.sv
// Top level of the line-following two-wheel speed controller.
// Depends on lfsc_pkg, lfsc_if and lfsc_wheel.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        action, left/right_delta, sensor_left/centre/right
//   out_ch    out  valid/ready        left/right_drive, brake, stop_cause, line_pattern
//   cfg       in   cfg_we             cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: an input register, one pass of logic, a result register.
// The result is valid once the item passes from the input register into the result register.
// Move state (positions, speeds, references, stop cause) updates as an item
// leaves the input register, so the next item sees it at once.
// A stalled output holds its result; the input register keeps taking items
// until both registers are full. Reset is synchronous and clears all control.
module line_follow_speed_control #(
  parameter int POSITION_BITS  = lfsc_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRAC_BITS = lfsc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  lfsc_in_if.sink                              in_ch,
  lfsc_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [lfsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lfsc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import lfsc_pkg::*;

  localparam int CMP_BITS = (POSITION_BITS > CFG_DATA_BITS) ? POSITION_BITS : CFG_DATA_BITS;

  logic        seek_mode;
  logic        horiz_stop;
  logic [22:0] target_counts;
  logic [9:0]  line_threshold;
  logic [7:0]  base_reference;
  logic [7:0]  steer_minor;
  logic [7:0]  steer_major;
  logic [7:0]  speed_gain;

  logic              in_valid;
  logic              in_action;
  logic signed [9:0] in_left_delta;
  logic signed [9:0] in_right_delta;
  logic        [9:0] in_sensor_left;
  logic        [9:0] in_sensor_centre;
  logic        [9:0] in_sensor_right;

  logic              out_valid;
  logic signed [8:0] out_left_drive;
  logic signed [8:0] out_right_drive;
  logic              out_brake;
  logic        [1:0] out_stop_cause;
  logic        [2:0] out_line_pattern;

  logic advance;

  stop_cause_t reason;
  stop_cause_t reason_next;
  logic signed [REF_BITS-1:0] left_ref;
  logic signed [REF_BITS-1:0] left_ref_next;
  logic signed [REF_BITS-1:0] right_ref;
  logic signed [REF_BITS-1:0] right_ref_next;
  logic signed [REF_BITS-1:0] base_ext;
  logic signed [REF_BITS-1:0] minor_ext;
  logic signed [REF_BITS-1:0] major_ext;

  logic [2:0]  pattern;
  logic        drive_zero;
  wheel_ctrl_t ctrl;
  wheel_ctrl_t wheel_ctrl;

  logic [POSITION_BITS-1:0] left_mag;
  logic [POSITION_BITS-1:0] right_mag;
  logic signed [8:0]        left_drive;
  logic signed [8:0]        right_drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      seek_mode      <= 1'b0;
      horiz_stop     <= 1'b0;
      target_counts  <= '0;
      line_threshold <= LINE_THRESHOLD_RESET;
      base_reference <= BASE_REFERENCE_RESET;
      steer_minor    <= STEER_MINOR_RESET;
      steer_major    <= STEER_MAJOR_RESET;
      speed_gain     <= SPEED_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SEEK_MODE:      seek_mode      <= cfg_data[0];
        CFG_HORIZ_STOP:     horiz_stop     <= cfg_data[0];
        CFG_TARGET_COUNTS:  target_counts  <= cfg_data[22:0];
        CFG_LINE_THRESHOLD: line_threshold <= cfg_data[9:0];
        CFG_BASE_REFERENCE: base_reference <= cfg_data[7:0];
        CFG_STEER_MINOR:    steer_minor    <= cfg_data[7:0];
        CFG_STEER_MAJOR:    steer_major    <= cfg_data[7:0];
        CFG_SPEED_GAIN:     speed_gain     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_action        <= in_ch.action;
      in_left_delta    <= in_ch.left_delta;
      in_right_delta   <= in_ch.right_delta;
      in_sensor_left   <= in_ch.sensor_left;
      in_sensor_centre <= in_ch.sensor_centre;
      in_sensor_right  <= in_ch.sensor_right;
    end
  end

  assign pattern = {in_sensor_left > line_threshold,
                    in_sensor_centre > line_threshold,
                    in_sensor_right > line_threshold};

  assign base_ext  = signed'({2'b00, base_reference});
  assign minor_ext = signed'({2'b00, steer_minor});
  assign major_ext = signed'({2'b00, steer_major});

  always_comb begin
    ctrl           = '0;
    reason_next    = reason;
    left_ref_next  = left_ref;
    right_ref_next = right_ref;
    drive_zero     = 1'b1;
    if (in_action == ACTION_START) begin
      ctrl.clear     = 1'b1;
      reason_next    = STOP_RUNNING;
      left_ref_next  = base_ext;
      right_ref_next = base_ext;
    end else if (reason == STOP_RUNNING) begin
      ctrl.pos_en = 1'b1;
      if (!seek_mode &&
          (CMP_BITS'(left_mag) >= CMP_BITS'(target_counts) ||
           CMP_BITS'(right_mag) >= CMP_BITS'(target_counts))) begin
        reason_next = STOP_DISTANCE;
      end else begin
        ctrl.speed_en = 1'b1;
        drive_zero    = 1'b0;
        if (seek_mode) begin
          if (pattern != PAT_NONE) begin
            reason_next = STOP_LINE;
          end
        end else begin
          case (pattern)
            PAT_CENTRE: begin
              left_ref_next  = base_ext;
              right_ref_next = base_ext;
            end
            PAT_RIGHT_MINOR: begin
              left_ref_next  = base_ext + minor_ext;
              right_ref_next = base_ext - minor_ext;
            end
            PAT_RIGHT_MAJOR: begin
              left_ref_next  = base_ext + major_ext;
              right_ref_next = base_ext - major_ext;
            end
            PAT_LEFT_MINOR: begin
              left_ref_next  = base_ext - minor_ext;
              right_ref_next = base_ext + minor_ext;
            end
            PAT_LEFT_MAJOR: begin
              left_ref_next  = base_ext - major_ext;
              right_ref_next = base_ext + major_ext;
            end
            PAT_ALL: begin
              if (horiz_stop) begin
                reason_next = STOP_HORIZONTAL;
              end
            end
            default: ;
          endcase
        end
        if (reason_next != STOP_RUNNING) begin
          drive_zero = 1'b1;
        end
      end
    end
  end

  assign wheel_ctrl = advance ? ctrl : '0;

  lfsc_wheel #(
    .POSITION_BITS  (POSITION_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (wheel_ctrl),
    .delta     (in_left_delta),
    .reference (left_ref),
    .gain      (speed_gain),
    .pos_mag   (left_mag),
    .drive     (left_drive)
  );

  lfsc_wheel #(
    .POSITION_BITS  (POSITION_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (wheel_ctrl),
    .delta     (in_right_delta),
    .reference (right_ref),
    .gain      (speed_gain),
    .pos_mag   (right_mag),
    .drive     (right_drive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reason    <= STOP_RUNNING;
      left_ref  <= signed'({2'b00, BASE_REFERENCE_RESET});
      right_ref <= signed'({2'b00, BASE_REFERENCE_RESET});
    end else if (advance) begin
      reason    <= reason_next;
      left_ref  <= left_ref_next;
      right_ref <= right_ref_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left_drive   <= drive_zero ? '0 : left_drive;
      out_right_drive  <= drive_zero ? '0 : right_drive;
      out_brake        <= (reason_next != STOP_RUNNING);
      out_stop_cause   <= reason_next;
      out_line_pattern <= pattern;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.left_drive   = out_left_drive;
  assign out_ch.right_drive  = out_right_drive;
  assign out_ch.brake        = out_brake;
  assign out_ch.stop_cause   = out_stop_cause;
  assign out_ch.line_pattern = out_line_pattern;

endmodule

// File: sv/lfsc_checker.sv
// Port-level checks for line_follow_speed_control, bound to the top level.
// Depends on lfsc_pkg and the top level's ports.
module lfsc_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] left_drive,
  input logic signed [8:0] right_drive,
  input logic              brake,
  input logic        [1:0] stop_cause,
  input logic        [2:0] line_pattern
);
  import lfsc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_drive) &&
      $stable(right_drive) && $stable(brake) && $stable(stop_cause) &&
      $stable(line_pattern))
    else $error("stalled result changed");

  a_brake_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (brake == (stop_cause != STOP_RUNNING)))
    else $error("brake disagrees with stop cause");

  a_brake_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && brake |-> left_drive == 9'sd0 && right_drive == 9'sd0)
    else $error("drive nonzero while braking");

endmodule

bind line_follow_speed_control lfsc_checker u_lfsc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .left_drive   (out_ch.left_drive),
  .right_drive  (out_ch.right_drive),
  .brake        (out_ch.brake),
  .stop_cause   (out_ch.stop_cause),
  .line_pattern (out_ch.line_pattern)
);
